@@ rtl/core/rau_pkg.sv @@
package rau_pkg;

	localparam int unsigned WordBits = 32;
	localparam int unsigned CntBits  = 6;

	typedef logic [WordBits-1:0] word_t;

	typedef enum logic [3:0] {
		CMD_ADD   = 4'd0,
		CMD_SUB   = 4'd1,
		CMD_RSUB  = 4'd2,
		CMD_MUL   = 4'd3,
		CMD_DIV   = 4'd4,
		CMD_NEG   = 4'd5,
		CMD_RECIP = 4'd6,
		CMD_NORM  = 4'd7,
		CMD_CMP   = 4'd8
	} cmd_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic  frac;
		logic  cmp;
		word_t p0;
		word_t p1;
		word_t q0;
		word_t q1;
		logic  add;
	} job_t;

	typedef struct packed {
		word_t num;
		word_t den;
		word_t diff;
		logic  less;
		logic  equal;
	} res_t;

	function automatic word_t wneg(input word_t x);
		return word_t'(0) - x;
	endfunction

endpackage

@@ rtl/core/rau_front.sv @@
module rau_front import rau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic [3:0] cmd,
	input  word_t a_num,
	input  word_t a_den,
	input  word_t b_num,
	input  word_t b_den,
	output logic  job_valid,
	input  logic  job_ready,
	output job_t  job
);

	logic  full_q;
	job_t  job_q;
	word_t inv_n, inv_d;
	job_t  nxt;

	assign in_ready  = !full_q || job_ready;
	assign job_valid = full_q;
	assign job       = job_q;

	// select multiplier operands per command
	always_comb begin
		inv_n = b_num[WordBits-1] ? wneg(b_den) : b_den;
		inv_d = b_num[WordBits-1] ? wneg(b_num) : b_num;
		nxt      = '0;
		nxt.frac = 1'b1;
		nxt.add  = 1'b0;
		case (cmd)
			CMD_ADD: begin
				nxt.p0 = a_num; nxt.p1 = b_den; nxt.q0 = a_den; nxt.q1 = b_num;
				nxt.add = 1'b1;
			end
			CMD_SUB: begin
				nxt.p0 = a_num; nxt.p1 = b_den; nxt.q0 = a_den; nxt.q1 = wneg(b_num);
				nxt.add = 1'b1;
			end
			CMD_RSUB: begin
				nxt.p0 = wneg(a_num); nxt.p1 = b_den; nxt.q0 = a_den; nxt.q1 = b_num;
				nxt.add = 1'b1;
			end
			CMD_MUL: begin
				nxt.p0 = a_num; nxt.p1 = b_num; nxt.q0 = a_den; nxt.q1 = b_den;
			end
			CMD_DIV: begin
				nxt.p0 = a_num; nxt.p1 = inv_n; nxt.q0 = a_den; nxt.q1 = inv_d;
			end
			CMD_NEG: begin
				nxt.p0 = wneg(a_num); nxt.p1 = word_t'(1); nxt.q0 = a_den;
				nxt.q1 = word_t'(1);
			end
			CMD_RECIP: begin
				nxt.p0 = a_num[WordBits-1] ? wneg(a_den) : a_den; nxt.p1 = word_t'(1);
				nxt.q0 = a_num[WordBits-1] ? wneg(a_num) : a_num; nxt.q1 = word_t'(1);
			end
			CMD_NORM: begin
				nxt.p0 = a_num; nxt.p1 = word_t'(1); nxt.q0 = a_den; nxt.q1 = word_t'(1);
			end
			CMD_CMP: begin
				nxt.frac = 1'b0; nxt.cmp = 1'b1;
				nxt.p0 = a_num; nxt.p1 = b_den; nxt.q0 = b_num; nxt.q1 = a_den;
			end
			default: begin
				nxt.frac = 1'b0;
			end
		endcase
	end

	// hold one classified transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_q <= nxt;
		end
	end

endmodule

@@ rtl/core/rau_divider.sv @@
module rau_divider import rau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t dividend,
	input  word_t divisor,
	output logic  done,
	output word_t quot,
	output word_t rem
);

	logic [CntBits-1:0] cnt_q;
	logic  busy_q;
	word_t q_q, r_q, d_q;
	logic [WordBits:0] trial;
	word_t r_sh;

	assign r_sh  = {r_q[WordBits-2:0], q_q[WordBits-1]};
	assign trial = {r_q[WordBits-1], r_sh} - {1'b0, d_q};
	assign quot  = q_q;
	assign rem   = r_q;
	assign done  = busy_q && (cnt_q == '0);

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntBits'(WordBits);
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - CntBits'(1);
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			if (!trial[WordBits]) begin
				r_q <= trial[WordBits-1:0];
				q_q <= {q_q[WordBits-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[WordBits-2:0], 1'b0};
			end
		end
	end

endmodule

@@ rtl/core/rau_back.sv @@
module rau_back import rau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_SUM  = 7'b0000100,
		ST_GCD  = 7'b0001000,
		ST_DIVN = 7'b0010000,
		ST_DIVD = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	job_t   job_q;
	word_t  m0_q, m1_q, x_q, y_q, g_q, qn_q;
	word_t  frac_n, frac_d;
	logic   sign_q;
	res_t   res_q;
	res_t   sum_res;
	logic   start;
	word_t  dv_a, dv_b, quot, rem, mag;
	logic   done;

	assign job_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;
	assign mag       = frac_n[WordBits-1] ? wneg(frac_n) : frac_n;

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(dv_a), .divisor(dv_b),
		.done(done), .quot(quot), .rem(rem)
	);

	// drive the shared divider from the state
	always_comb begin
		start = 1'b0;
		dv_a  = x_q;
		dv_b  = y_q;
		case (state_q)
			ST_SUM: begin
				// gcd(m, 0) is m, so a zero denominator goes straight to m / m
				start = job_q.frac && !(mag == '0 && frac_d == '0);
				dv_a  = mag;
				dv_b  = (frac_d == '0) ? mag : frac_d;
			end
			ST_GCD: begin
				// next Euclid step, or the magnitude over the gcd once it is found
				start = done;
				dv_a  = (rem != '0) ? y_q : mag;
				dv_b  = (rem != '0) ? rem : y_q;
			end
			ST_DIVN: begin
				start = done;
				dv_a  = frac_d;
				dv_b  = g_q;
			end
			default: begin
				start = 1'b0;
			end
		endcase
	end

	// sequence products, gcd and exact divisions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (job_valid) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM: begin
					if (!job_q.frac) state_q <= ST_OUT;
					else if (mag == '0 && frac_d == '0) state_q <= ST_OUT;
					else if (frac_d == '0) state_q <= ST_DIVN;
					else state_q <= ST_GCD;
				end
				ST_GCD:  if (done && rem == '0) state_q <= ST_DIVN;
				ST_DIVN: if (done) state_q <= ST_DIVD;
				ST_DIVD: if (done) state_q <= ST_OUT;
				ST_OUT:  if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// compare fields; fractions start from zero and 0/0 stays that way
	always_comb begin
		sum_res = '0;
		if (job_q.cmp) begin
			sum_res.diff  = m0_q - m1_q;
			sum_res.equal = (m0_q == m1_q);
			sum_res.less  = ($signed(m0_q) < $signed(m1_q));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (job_valid) job_q <= job;
			ST_MUL: begin
				m0_q <= word_t'(job_q.p0 * job_q.p1);
				m1_q <= word_t'(job_q.q0 * job_q.q1);
			end
			ST_SUM: begin
				res_q  <= sum_res;
				x_q    <= mag;
				y_q    <= frac_d;
				g_q    <= mag;
				sign_q <= frac_n[WordBits-1];
			end
			ST_GCD: begin
				if (done) begin
					y_q <= rem;
					g_q <= y_q;
				end
			end
			ST_DIVN: begin
				// first pass divides magnitude by gcd
				if (done) qn_q <= quot;
			end
			ST_DIVD: begin
				if (done) begin
					res_q.num <= sign_q ? wneg(qn_q) : qn_q;
					res_q.den <= quot;
				end
			end
			default: begin
			end
		endcase
	end

	// fraction operands after products
	always_comb begin
		frac_n = job_q.add ? m0_q + m1_q : m0_q;
		frac_d = job_q.add ? word_t'(job_q.p1 * job_q.q0) : m1_q;
	end

endmodule

@@ rtl/core/rational_arithmetic_unit_top.sv @@
// Channel | Ports                                  | Handshake
// in      | cmd a_num a_den b_num b_den            | push / full
// out     | res_num res_den cross_diff is_less ... | pop / empty
// Compare and unused codes do not use the divider. A fraction transaction
// uses the shared restoring divider once per Euclid step (at most about 46)
// and twice more for the exact divisions. The front holds one classified
// transaction so a new push lands while the back works. Reset clears all
// control state. A stalled result holds on the ports until popped.
module rational_arithmetic_unit_top import rau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [3:0]  cmd,
	input  logic signed [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic [31:0] b_den,
	output logic        empty,
	input  logic        pop,
	output logic signed [31:0] res_num,
	output logic [31:0] res_den,
	output logic signed [31:0] cross_diff,
	output logic        is_less,
	output logic        is_equal
);

	logic job_valid, job_ready, in_ready, res_valid;
	job_t job;
	res_t res;

	assign full = !in_ready;
	assign empty = !res_valid;
	assign res_num = res.num;
	assign res_den = res.den;
	assign cross_diff = res.diff;
	assign is_less = res.less;
	assign is_equal = res.equal;

	rau_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push), .in_ready(in_ready), .cmd(cmd),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	rau_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready),
		.job(job), .res_valid(res_valid), .res_ready(pop), .res(res)
	);

endmodule

@@ rtl/core/rau_checker.sv @@
module rau_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input logic [31:0] res_den,
	input logic is_less,
	input logic is_equal
);

	// a waiting result stays until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("result dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(res_den)) else $error("result changed");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(is_less && is_equal)) else $error("less and equal");
	a_reset: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("not empty in reset");

endmodule

bind rational_arithmetic_unit_top rau_checker u_chk (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty), .pop(pop),
	.res_den(res_den), .is_less(is_less), .is_equal(is_equal)
);

@@ bench/tb_rational_arithmetic_unit_top.sv @@
module tb_rational_arithmetic_unit_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	localparam int unsigned WatchLimit = 20000;
	localparam int unsigned NumRandom  = 2000;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] an;
		logic [31:0] ad;
		logic [31:0] bn;
		logic [31:0] bd;
	} operand_t;

	typedef struct {
		logic [31:0] num;
		logic [31:0] den;
		logic [31:0] diff;
		logic        less;
		logic        equal;
	} fraction_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [3:0]  cmd = '0;
	logic signed [31:0] a_num = '0;
	logic [31:0] a_den = '0;
	logic signed [31:0] b_num = '0;
	logic [31:0] b_den = '0;
	logic        full, empty;
	logic signed [31:0] res_num;
	logic [31:0] res_den;
	logic signed [31:0] cross_diff;
	logic        is_less, is_equal;

	operand_t  pending_ops[$];
	fraction_t awaited_results[$];
	int unsigned error_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_pop = 1'b0;
	int unsigned quiet_cycles = 0;

	rational_arithmetic_unit_top dut (.*);

	always #6 clk = ~clk;

	// Euclid on magnitudes, gcd(0,0) taken as 1
	function automatic logic [31:0] euclid_gcd(input logic [31:0] x, input logic [31:0] y);
		logic [31:0] t;
		if (x == 0 && y == 0)
			return 32'd1;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic void reduce_fraction(input logic [31:0] n, input logic [31:0] d,
			output logic [31:0] rn, output logic [31:0] rd);
		logic [31:0] mag, g, q;
		mag = n[31] ? 32'd0 - n : n;
		g = euclid_gcd(mag, d);
		q = mag / g;
		rn = n[31] ? 32'd0 - q : q;
		rd = d / g;
	endfunction

	// move the sign to the numerator when flipping
	function automatic void flip_fraction(input logic [31:0] n, input logic [31:0] d,
			output logic [31:0] fn, output logic [31:0] fd);
		if (n[31]) begin
			fn = 32'd0 - d;
			fd = 32'd0 - n;
		end else begin
			fn = d;
			fd = n;
		end
	endfunction

	function automatic fraction_t rational_result(input operand_t o);
		fraction_t r;
		logic [31:0] n, d, xn, xd, p, q;
		bit frac;
		r = '{default: '0};
		frac = 1'b1;
		n = '0;
		d = '0;
		case (o.op)
			CMD_ADD: begin
				n = o.an * o.bd + o.ad * o.bn; d = o.ad * o.bd;
			end
			CMD_SUB: begin
				n = o.an * o.bd - o.ad * o.bn; d = o.ad * o.bd;
			end
			CMD_RSUB: begin
				n = (32'd0 - o.an) * o.bd + o.ad * o.bn; d = o.ad * o.bd;
			end
			CMD_MUL: begin
				n = o.an * o.bn; d = o.ad * o.bd;
			end
			CMD_DIV: begin
				flip_fraction(o.bn, o.bd, xn, xd);
				n = o.an * xn; d = o.ad * xd;
			end
			CMD_NEG: begin
				n = 32'd0 - o.an; d = o.ad;
			end
			CMD_RECIP: flip_fraction(o.an, o.ad, n, d);
			CMD_NORM: begin
				n = o.an; d = o.ad;
			end
			CMD_CMP: begin
				p = o.an * o.bd;
				q = o.bn * o.ad;
				r.diff = p - q;
				r.equal = (p == q);
				r.less = $signed(p) < $signed(q);
				frac = 1'b0;
			end
			default: frac = 1'b0;
		endcase
		if (frac)
			reduce_fraction(n, d, r.num, r.den);
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 12);
			1: return 32'd0 - $urandom_range(1, 12);
			2: return {1'b1, 31'(0)} ^ $urandom_range(0, 1);
			3: return 32'h7fffffff - $urandom_range(0, 1);
			4: return $urandom_range(1, 1000) * $urandom_range(1, 60);
			default: return $urandom;
		endcase
	endfunction

	function automatic operand_t rand_operand();
		operand_t o;
		o.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(CMD_ADD, CMD_CMP));
		o.an = rand_word();
		o.ad = rand_word();
		o.bn = rand_word();
		o.bd = rand_word();
		return o;
	endfunction

	// drive the next transaction once the previous one is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				if (pending_ops.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
					operand_t o;
					o = pending_ops.pop_front();
					awaited_results.push_back(rational_result(o));
					cmd <= o.op; a_num <= o.an; a_den <= o.ad; b_num <= o.bn; b_den <= o.bd;
				end else
					push <= 1'b0;
			end else if (!push) begin
				if (pending_ops.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
					operand_t o;
					o = pending_ops.pop_front();
					awaited_results.push_back(rational_result(o));
					cmd <= o.op; a_num <= o.an; a_den <= o.ad; b_num <= o.bn; b_den <= o.bd;
					push <= 1'b1;
				end
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		error_count++;
	endtask

	// check each popped transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					$display("mismatch: unexpected result");
					error_count++;
				end else begin
					fraction_t e;
					e = awaited_results.pop_front();
					if (res_num !== e.num) report_mismatch("res_num", res_num, e.num);
					if (res_den !== e.den) report_mismatch("res_den", res_den, e.den);
					if (cross_diff !== e.diff) report_mismatch("cross_diff", cross_diff, e.diff);
					if (is_less !== e.less)
						report_mismatch("is_less", 32'(is_less), 32'(e.less));
					if (is_equal !== e.equal)
						report_mismatch("is_equal", 32'(is_equal), 32'(e.equal));
				end
			end
			pop <= !hold_pop && ($urandom_range(1, 100) > recv_stall_pct);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (quiet_cycles >= WatchLimit) begin
			$display("watchdog expired");
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic drain();
		while (pending_ops.size() > 0 || push || awaited_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		operand_t o;
		logic [31:0] edge_vals[6];
		edge_vals = '{32'd0, 32'd1, 32'hffffffff, 32'h80000000, 32'h7fffffff, 32'd6};
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every opcode over extreme operands, plus zero denominators
		for (int i = 0; i <= 10; i++) begin
			o.op = (i == 10) ? 4'd15 : (i == 9) ? 4'd9 : 4'(i);
			o.an = edge_vals[i % 6];
			o.ad = edge_vals[(i + 2) % 6];
			o.bn = edge_vals[(i + 3) % 6];
			o.bd = edge_vals[(i + 1) % 6];
			pending_ops.push_back(o);
		end
		pending_ops.push_back('{CMD_NORM, 32'd0, 32'd0, 32'd0, 32'd0});
		pending_ops.push_back('{CMD_NORM, 32'd0, 32'd9, 32'd0, 32'd0});
		pending_ops.push_back('{CMD_RECIP, 32'hfffffffa, 32'h80000004, 32'd0, 32'd0});
		pending_ops.push_back('{CMD_NEG, 32'h80000000, 32'd4, 32'd0, 32'd0});
		pending_ops.push_back('{CMD_DIV, 32'd3, 32'd4, 32'hfffffffe, 32'h80000000});
		pending_ops.push_back('{CMD_CMP, 32'd1, 32'd2, 32'd2, 32'd4});
		pending_ops.push_back('{CMD_CMP, 32'h7fffffff, 32'd2, 32'd1, 32'd1});
		pending_ops.push_back('{CMD_ADD, 32'hffffffff, 32'hffffffff, 32'h7fffffff,
			32'h80000000});
		drain();

		// long receiver hold-off so the block fills and stalls its input
		hold_pop = 1'b1;
		for (int i = 0; i < 8; i++)
			pending_ops.push_back(rand_operand());
		repeat (3000) @(posedge clk);
		hold_pop = 1'b0;
		drain();

		// random phases with different idle mixes
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 49) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 49) : 0;
			for (int i = 0; i < NumRandom / 4; i++)
				pending_ops.push_back(rand_operand());
			drain();
		end
		repeat (500) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
